[rtl/brfifo_pkg.sv]
// Shared definitions for the byte ring FIFO with statistics: field widths,
// command and result codes, the sequencer state type and capacity clamping.
// No dependencies.
package brfifo_pkg;

   localparam int CMD_W   = 2;
   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 7;
   localparam int KIND_W  = 2;
   localparam int CAP_W   = 13;
   localparam int CALL_W  = 32;

   localparam int DEPTH_DEFAULT    = 4096;
   localparam int MAX_READ_DEFAULT = 64;
   localparam int CAP_RESET_LIMIT  = 4096;

   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_STATS = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RSVD  = 2'd3;

   localparam logic [KIND_W-1:0] KIND_READ_DATA  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE_DONE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ_EMPTY = 2'd2;
   localparam logic [KIND_W-1:0] KIND_STATS      = 2'd3;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_BLOCK = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

   // A capacity of zero is taken as one, anything above the depth as the depth.
   function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAP_W-1:0] v,
                                                  input int unsigned depth);
      if (v == '0) begin
         return CAP_W'(1);
      end
      if (32'(v) > depth) begin
         return CAP_W'(depth);
      end
      return v;
   endfunction

endpackage

[rtl/brfifo_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// The read data holds its value while no read is issued. No dependencies.
module brfifo_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/byte_ring_fifo_with_stats.sv]
// Top level of the byte ring FIFO with statistics: sequencer, pointers,
// counters and result register. Depends on brfifo_pkg and brfifo_ram.
//
//   Channel   Direction  Handshake                 Carries
//   req_      in         req_valid / req_stall     command, byte, marks, length
//   rsp_      out        rsp_valid / rsp_stall     result kind, data, counts
//   csr_      in         csr_write_enable          capacity
//
// A write byte, a statistics query or a read that returns no data is handled
// in the idle state. A read returning n bytes first issues the storage read;
// then each cycle in which the result register is free delivers one byte while
// issuing the next, limited by the single read port of the storage RAM.
// Reset is synchronous and clears all control state and counters; storage is
// not cleared. A stalled result channel holds the sequencer and blocks any
// request that needs a result slot.
module byte_ring_fifo_with_stats #(
   parameter int DEPTH    = brfifo_pkg::DEPTH_DEFAULT,
   parameter int MAX_READ = brfifo_pkg::MAX_READ_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [brfifo_pkg::CMD_W-1:0]     req_command,
   input  logic [brfifo_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic                             req_first_of_write,
   input  logic                             req_last_of_write,
   input  logic [brfifo_pkg::LEN_W-1:0]     req_read_length,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [brfifo_pkg::KIND_W-1:0]    rsp_result_kind,
   output logic                             rsp_status,
   output logic [brfifo_pkg::BYTE_W-1:0]    rsp_data_byte_out,
   output logic [brfifo_pkg::CAP_W-1:0]     rsp_transfer_count,
   output logic                             rsp_last,
   output logic [brfifo_pkg::CAP_W-1:0]     rsp_used_bytes,
   output logic [brfifo_pkg::CAP_W-1:0]     rsp_free_bytes,
   output logic [brfifo_pkg::CALL_W-1:0]    rsp_read_calls,
   output logic [brfifo_pkg::CALL_W-1:0]    rsp_write_calls,
   input  logic                             csr_write_enable,
   input  logic [brfifo_pkg::CAP_W-1:0]     csr_write_data
);

   import brfifo_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int PW = ((AW > CAP_W) ? AW : CAP_W) + 1;
   localparam logic [CAP_W-1:0] CAP_RESET =
      CAP_W'((DEPTH < CAP_RESET_LIMIT) ? DEPTH : CAP_RESET_LIMIT);
   localparam logic [CAP_W-1:0] ACC_MAX = '1;

   function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p,
                                              input logic [CAP_W-1:0] cap);
      logic [PW-1:0] inc;
      inc = PW'(p) + PW'(1);
      if (inc >= PW'(cap)) begin
         return '0;
      end
      return AW'(inc);
   endfunction

   // Control state
   state_type          state_ff, state_in;
   logic [AW-1:0]      rptr_ff, rptr_in;
   logic [AW-1:0]      wptr_ff, wptr_in;
   logic [CAP_W-1:0]   fill_ff, fill_in;
   logic [CAP_W-1:0]   cap_ff, cap_in;
   logic [CALL_W-1:0]  rd_total_ff, rd_total_in;
   logic [CALL_W-1:0]  wr_total_ff, wr_total_in;
   logic               wrej_ff, wrej_in;
   logic [CAP_W-1:0]   wacc_ff, wacc_in;
   logic [LEN_W-1:0]   rnum_ff, rnum_in;
   logic [LEN_W-1:0]   rcnt_ff, rcnt_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Result payload
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic               status_ff, status_in;
   logic [BYTE_W-1:0]  dout_ff, dout_in;
   logic [CAP_W-1:0]   count_ff, count_in;
   logic               last_ff, last_in;
   logic [CAP_W-1:0]   used_ff, used_in;
   logic [CAP_W-1:0]   free_ff, free_in;
   logic [CALL_W-1:0]  rcalls_ff, rcalls_in;
   logic [CALL_W-1:0]  wcalls_ff, wcalls_in;

   logic               out_free;
   logic               out_load;
   logic               needs_out;
   logic               req_take;
   logic               wr_rej;
   logic [CAP_W-1:0]   wr_acc;
   logic               wr_store;
   logic [LEN_W-1:0]   len_sat;
   logic [LEN_W-1:0]   rd_num;
   logic               ram_we;
   logic               ram_re;
   logic [BYTE_W-1:0]  ram_rdata;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign needs_out = !((req_command == CMD_WRITE) && !req_last_of_write) &&
                      (req_command != CMD_RSVD);
   assign req_stall = !((state_ff == ST_IDLE) && (out_free || !needs_out));
   assign req_take  = req_valid && !req_stall;

   // Write request bookkeeping for the current byte.
   assign wr_rej   = req_first_of_write ? (fill_ff >= cap_ff) : wrej_ff;
   assign wr_store = !wr_rej && (fill_ff < cap_ff);
   always_comb begin
      wr_acc = req_first_of_write ? '0 : wacc_ff;
      if (wr_store && (wr_acc != ACC_MAX)) begin
         wr_acc = wr_acc + CAP_W'(1);
      end
   end

   assign len_sat = (32'(req_read_length) > 32'(MAX_READ)) ? LEN_W'(MAX_READ)
                                                           : req_read_length;
   assign rd_num  = (CAP_W'(len_sat) < fill_ff) ? len_sat : LEN_W'(fill_ff);

   always_comb begin
      state_in    = state_ff;
      rptr_in     = rptr_ff;
      wptr_in     = wptr_ff;
      fill_in     = fill_ff;
      cap_in      = cap_ff;
      rd_total_in = rd_total_ff;
      wr_total_in = wr_total_ff;
      wrej_in     = wrej_ff;
      wacc_in     = wacc_ff;
      rnum_in     = rnum_ff;
      rcnt_in     = rcnt_ff;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      out_load    = 1'b0;
      kind_in     = KIND_READ_DATA;
      status_in   = STATUS_OK;
      dout_in     = '0;
      count_in    = '0;
      last_in     = 1'b0;
      used_in     = '0;
      free_in     = '0;
      rcalls_in   = '0;
      wcalls_in   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               unique case (req_command)
                  CMD_WRITE: begin
                     if (wr_store) begin
                        ram_we  = 1'b1;
                        wptr_in = next_ptr(wptr_ff, cap_ff);
                        fill_in = fill_ff + CAP_W'(1);
                     end
                     if (req_last_of_write) begin
                        out_load  = 1'b1;
                        kind_in   = KIND_WRITE_DONE;
                        status_in = wr_rej ? STATUS_BLOCK : STATUS_OK;
                        count_in  = wr_rej ? '0 : wr_acc;
                        last_in   = 1'b1;
                        if (!wr_rej) begin
                           wr_total_in = wr_total_ff + CALL_W'(1);
                        end
                        wrej_in = 1'b0;
                        wacc_in = '0;
                     end else begin
                        wrej_in = wr_rej;
                        wacc_in = wr_acc;
                     end
                  end
                  CMD_READ: begin
                     if ((len_sat == '0) || (fill_ff == '0)) begin
                        out_load  = 1'b1;
                        kind_in   = KIND_READ_EMPTY;
                        status_in = (len_sat == '0) ? STATUS_OK : STATUS_BLOCK;
                        last_in   = 1'b1;
                     end else begin
                        // The first byte is fetched now and delivered from the read state.
                        ram_re      = 1'b1;
                        rptr_in     = next_ptr(rptr_ff, cap_ff);
                        fill_in     = fill_ff - CAP_W'(rd_num);
                        rd_total_in = rd_total_ff + CALL_W'(1);
                        rnum_in     = rd_num;
                        rcnt_in     = '0;
                        state_in    = ST_READ;
                     end
                  end
                  CMD_STATS: begin
                     out_load  = 1'b1;
                     kind_in   = KIND_STATS;
                     last_in   = 1'b1;
                     used_in   = fill_ff;
                     free_in   = cap_ff - fill_ff;
                     rcalls_in = rd_total_ff;
                     wcalls_in = wr_total_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            // The RAM output holds until the result register can take it.
            if (out_free) begin
               out_load = 1'b1;
               kind_in  = KIND_READ_DATA;
               dout_in  = ram_rdata;
               rcnt_in  = rcnt_ff + LEN_W'(1);
               if (rcnt_in == rnum_ff) begin
                  last_in  = 1'b1;
                  count_in = CAP_W'(rnum_ff);
                  state_in = ST_IDLE;
               end else begin
                  ram_re  = 1'b1;
                  rptr_in = next_ptr(rptr_ff, cap_ff);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A capacity change is only honoured while the ring is empty.
      if (csr_write_enable && (fill_ff == '0)) begin
         cap_in  = clamp_cap(csr_write_data, DEPTH);
         rptr_in = '0;
         wptr_in = '0;
      end
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rptr_ff      <= '0;
         wptr_ff      <= '0;
         fill_ff      <= '0;
         cap_ff       <= CAP_RESET;
         rd_total_ff  <= '0;
         wr_total_ff  <= '0;
         wrej_ff      <= 1'b0;
         wacc_ff      <= '0;
         rnum_ff      <= '0;
         rcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rptr_ff      <= rptr_in;
         wptr_ff      <= wptr_in;
         fill_ff      <= fill_in;
         cap_ff       <= cap_in;
         rd_total_ff  <= rd_total_in;
         wr_total_ff  <= wr_total_in;
         wrej_ff      <= wrej_in;
         wacc_ff      <= wacc_in;
         rnum_ff      <= rnum_in;
         rcnt_ff      <= rcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         kind_ff   <= kind_in;
         status_ff <= status_in;
         dout_ff   <= dout_in;
         count_ff  <= count_in;
         last_ff   <= last_in;
         used_ff   <= used_in;
         free_ff   <= free_in;
         rcalls_ff <= rcalls_in;
         wcalls_ff <= wcalls_in;
      end
   end

   // Reads and writes never share a cycle: a write byte is accepted only in
   // the idle state, and a read issued in the cycle after already sees it.
   brfifo_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_storage (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wptr_ff),
      .wr_data (req_data_byte),
      .rd_en   (ram_re),
      .rd_addr (rptr_ff),
      .rd_data (ram_rdata)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = kind_ff;
   assign rsp_status         = status_ff;
   assign rsp_data_byte_out  = dout_ff;
   assign rsp_transfer_count = count_ff;
   assign rsp_last           = last_ff;
   assign rsp_used_bytes     = used_ff;
   assign rsp_free_bytes     = free_ff;
   assign rsp_read_calls     = rcalls_ff;
   assign rsp_write_calls    = wcalls_ff;

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= cap_ff)
      else $error("fill level exceeds capacity");

   a_ptrs_in_ring: assert property (@(posedge clock) disable iff (reset)
      (PW'(rptr_ff) < PW'(cap_ff)) && (PW'(wptr_ff) < PW'(cap_ff)))
      else $error("ring pointer outside capacity");

   a_no_port_clash: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("storage read and write in the same cycle");

   a_read_progress: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (rcnt_ff < rnum_ff))
      else $error("read burst count overran its length");

   a_read_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) && out_free && (rcnt_ff + LEN_W'(1) == rnum_ff)
      |=> rsp_valid && rsp_last && (state_ff == ST_IDLE))
      else $error("final byte of a read not marked last");

endmodule

[tb/byte_ring_fifo_with_stats_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for byte_ring_fifo_with_stats: directed and random
// requests against a shadow copy of the ring. Depends on brfifo_pkg and the RTL.
module byte_ring_fifo_with_stats_test;
   import brfifo_pkg::*;

   localparam int RING_SIZE      = DEPTH_DEFAULT;
   localparam int READ_LIMIT     = MAX_READ_DEFAULT;
   localparam int COUNT_MAX      = (1 << CAP_W) - 1;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 500;
   localparam int PHASE_ITEMS    = 16;
   localparam int unsigned PHASE_CAPS [8] = '{2, 7, 0, 16, 8191, 33, 4096, 1};

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              status;
      logic [BYTE_W-1:0] data;
      logic [CAP_W-1:0]  count;
      logic              last;
      logic [CAP_W-1:0]  used;
      logic [CAP_W-1:0]  room;
      logic [CALL_W-1:0] reads;
      logic [CALL_W-1:0] writes;
   } fifo_result_type;

   // Shadow of the ring: predicts the results of each accepted request and
   // checks what the block returns against them in order.
   class fifo_shadow_type;
      bit [BYTE_W-1:0] ring [RING_SIZE];
      int unsigned     rd_ptr, wr_ptr, fill;
      int unsigned     capacity;
      bit [CALL_W-1:0] read_total, write_total;
      bit              write_blocked;
      int unsigned     write_taken;
      fifo_result_type pending [$];
      int unsigned     failures;

      function new();
         capacity = (RING_SIZE < CAP_RESET_LIMIT) ? RING_SIZE : CAP_RESET_LIMIT;
      endfunction

      function int unsigned next_slot(int unsigned p);
         return (p + 1 >= capacity) ? 0 : p + 1;
      endfunction

      function string describe(fifo_result_type r);
         return $sformatf({"kind %0d status %0d data %02h count %0d last %0d",
                           " used %0d free %0d reads %0d writes %0d"},
                          r.kind, r.status, r.data, r.count, r.last, r.used,
                          r.room, r.reads, r.writes);
      endfunction

      function void flag_failure(string msg);
         failures++;
         if (failures <= 10) $display("%0t: %s", $realtime, msg);
      endfunction

      // The register only takes a value while the ring is empty.
      function void configure(logic [CAP_W-1:0] value);
         if (fill != 0) return;
         if (value == 0) capacity = 1;
         else if (value > RING_SIZE) capacity = RING_SIZE;
         else capacity = value;
         rd_ptr = 0;
         wr_ptr = 0;
      endfunction

      function void queue_result(logic [KIND_W-1:0] kind, logic status,
                                 logic [BYTE_W-1:0] data, int unsigned count,
                                 logic last, int unsigned used, int unsigned room,
                                 bit [CALL_W-1:0] reads, bit [CALL_W-1:0] writes);
         fifo_result_type r;
         r.kind   = kind;
         r.status = status;
         r.data   = data;
         r.count  = CAP_W'(count);
         r.last   = last;
         r.used   = CAP_W'(used);
         r.room   = CAP_W'(room);
         r.reads  = reads;
         r.writes = writes;
         pending.push_back(r);
      endfunction

      function void take_request(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data,
                                 logic first, logic last_mark,
                                 logic [LEN_W-1:0] len);
         int unsigned n;
         case (cmd)
            CMD_WRITE: begin
               // A full ring at the first byte rejects the whole request.
               if (first) begin
                  write_blocked = (fill >= capacity);
                  write_taken = 0;
               end
               if (!write_blocked && fill < capacity) begin
                  ring[wr_ptr] = data;
                  wr_ptr = next_slot(wr_ptr);
                  fill++;
                  if (write_taken < COUNT_MAX) write_taken++;
               end
               if (last_mark) begin
                  queue_result(KIND_WRITE_DONE, write_blocked ? STATUS_BLOCK : STATUS_OK,
                               '0, write_blocked ? 0 : write_taken, 1'b1, 0, 0, 0, 0);
                  if (!write_blocked) write_total++;
                  write_blocked = 1'b0;
                  write_taken = 0;
               end
            end
            CMD_READ: begin
               n = (len > READ_LIMIT) ? READ_LIMIT : len;
               if (n == 0) begin
                  queue_result(KIND_READ_EMPTY, STATUS_OK, '0, 0, 1'b1, 0, 0, 0, 0);
               end else if (fill == 0) begin
                  queue_result(KIND_READ_EMPTY, STATUS_BLOCK, '0, 0, 1'b1, 0, 0, 0, 0);
               end else begin
                  if (n > fill) n = fill;
                  for (int unsigned i = 1; i <= n; i++) begin
                     queue_result(KIND_READ_DATA, STATUS_OK, ring[rd_ptr],
                                  (i == n) ? n : 0, i == n, 0, 0, 0, 0);
                     rd_ptr = next_slot(rd_ptr);
                  end
                  fill -= n;
                  read_total++;
               end
            end
            CMD_STATS: begin
               queue_result(KIND_STATS, STATUS_OK, '0, 0, 1'b1, fill, capacity - fill,
                            read_total, write_total);
            end
            default: ;
         endcase
      endfunction

      function void check_result(fifo_result_type got);
         fifo_result_type want;
         if (pending.size() == 0) begin
            flag_failure({"unexpected result: ", describe(got)});
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            flag_failure({"result mismatch\n   expected ", describe(want),
                          "\n   actual   ", describe(got)});
         end
      endfunction
   endclass

   logic                clock              = 1'b0;
   logic                reset              = 1'b1;
   logic                req_valid          = 1'b0;
   logic                req_stall;
   logic [CMD_W-1:0]    req_command        = CMD_STATS;
   logic [BYTE_W-1:0]   req_data_byte      = '0;
   logic                req_first_of_write = 1'b0;
   logic                req_last_of_write  = 1'b0;
   logic [LEN_W-1:0]    req_read_length    = '0;
   logic                rsp_valid;
   logic                rsp_stall          = 1'b0;
   logic [KIND_W-1:0]   rsp_result_kind;
   logic                rsp_status;
   logic [BYTE_W-1:0]   rsp_data_byte_out;
   logic [CAP_W-1:0]    rsp_transfer_count;
   logic                rsp_last;
   logic [CAP_W-1:0]    rsp_used_bytes;
   logic [CAP_W-1:0]    rsp_free_bytes;
   logic [CALL_W-1:0]   rsp_read_calls;
   logic [CALL_W-1:0]   rsp_write_calls;
   logic                csr_write_enable   = 1'b0;
   logic [CAP_W-1:0]    csr_write_data     = '0;

   bit              idle_on      = 1'b0;
   int unsigned     stall_left   = 0;
   int unsigned     quiet_cycles = 0;
   int unsigned     items_sent   = 0;
   fifo_shadow_type shadow;

   byte_ring_fifo_with_stats DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_data_byte      (req_data_byte),
      .req_first_of_write (req_first_of_write),
      .req_last_of_write  (req_last_of_write),
      .req_read_length    (req_read_length),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_status         (rsp_status),
      .rsp_data_byte_out  (rsp_data_byte_out),
      .rsp_transfer_count (rsp_transfer_count),
      .rsp_last           (rsp_last),
      .rsp_used_bytes     (rsp_used_bytes),
      .rsp_free_bytes     (rsp_free_bytes),
      .rsp_read_calls     (rsp_read_calls),
      .rsp_write_calls    (rsp_write_calls),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   always #6 clock = ~clock;

   // Result side back-pressure, applied in random bursts while idle_on is set.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 3);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Result checking and the watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         shadow.check_result('{kind: rsp_result_kind, status: rsp_status,
                               data: rsp_data_byte_out, count: rsp_transfer_count,
                               last: rsp_last, used: rsp_used_bytes,
                               room: rsp_free_bytes, reads: rsp_read_calls,
                               writes: rsp_write_calls});
      end
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("byte_ring_fifo_with_stats_test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data,
                            logic first, logic last_mark, logic [LEN_W-1:0] len);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_command        <= cmd;
      req_data_byte      <= data;
      req_first_of_write <= first;
      req_last_of_write  <= last_mark;
      req_read_length    <= len;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      shadow.take_request(cmd, data, first, last_mark, len);
      if (cmd != CMD_RSVD) items_sent++;
   endtask

   task automatic write_byte(logic [BYTE_W-1:0] data, logic first, logic last_mark);
      send_item(CMD_WRITE, data, first, last_mark, LEN_W'($urandom));
   endtask

   task automatic read_request(logic [LEN_W-1:0] len);
      send_item(CMD_READ, BYTE_W'($urandom), 1'($urandom), 1'($urandom), len);
   endtask

   task automatic stats_query();
      send_item(CMD_STATS, BYTE_W'($urandom), 1'($urandom), 1'($urandom),
                LEN_W'($urandom));
   endtask

   // Waits for every outstanding result, then for a write byte still in flight.
   task automatic settle();
      req_valid <= 1'b0;
      while (shadow.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] value);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      shadow.configure(value);
   endtask

   task automatic drain_ring();
      while (shadow.fill != 0) read_request(LEN_W'(READ_LIMIT));
   endtask

   // Mostly well-formed write requests with reads and queries mixed in,
   // plus loose write bytes and reserved commands as noise.
   task automatic random_phase(int unsigned quota);
      int unsigned start, pick, len, bound;
      start = items_sent;
      while (items_sent - start < quota) begin
         if ($urandom_range(0, 19) == 0) idle_on = !idle_on;
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            bound = (shadow.capacity + 3 > 24) ? 24 : shadow.capacity + 3;
            len = $urandom_range(1, bound);
            for (int unsigned k = 0; k < len; k++) begin
               write_byte(BYTE_W'($urandom), k == 0, k == len - 1);
               if (k != len - 1 && $urandom_range(0, 9) == 0) begin
                  if ($urandom_range(0, 1) == 0) read_request(LEN_W'($urandom_range(1, 8)));
                  else stats_query();
               end
            end
         end else if (pick < 72) begin
            if ($urandom_range(0, 6) == 0) read_request(LEN_W'($urandom));
            else read_request(LEN_W'($urandom_range(1, 20)));
         end else if (pick < 84) begin
            stats_query();
         end else if (pick < 96) begin
            write_byte(BYTE_W'($urandom), 1'($urandom), 1'($urandom));
         end else begin
            send_item(CMD_RSVD, BYTE_W'($urandom), 1'($urandom), 1'($urandom),
                      LEN_W'($urandom));
         end
      end
   endtask

   initial begin
      shadow = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset capacity.
      read_request(LEN_W'(5));
      read_request(LEN_W'(0));
      stats_query();
      write_byte(8'h00, 1'b1, 1'b0);
      write_byte(8'hFF, 1'b0, 1'b0);
      write_byte(8'hA5, 1'b0, 1'b1);
      write_byte(8'h5A, 1'b0, 1'b1);
      read_request(LEN_W'(127));
      send_item(CMD_RSVD, 8'h3C, 1'b1, 1'b1, LEN_W'(9));
      stats_query();

      // A zero capacity is taken as one byte; a read mid-request makes room again.
      write_capacity('0);
      write_byte(8'h11, 1'b1, 1'b0);
      write_byte(8'h22, 1'b0, 1'b0);
      stats_query();
      read_request(LEN_W'(1));
      write_byte(8'h33, 1'b0, 1'b1);
      write_byte(8'h44, 1'b1, 1'b1);
      read_request(LEN_W'(64));
      stats_query();

      // Oversized capacity clamps to the depth; a write while not empty is ignored.
      write_capacity(CAP_W'(COUNT_MAX));
      write_byte(8'h77, 1'b1, 1'b1);
      write_capacity(CAP_W'(3));
      read_request(LEN_W'(2));
      stats_query();

      idle_on = 1'b1;
      foreach (PHASE_CAPS[p]) begin
         drain_ring();
         if (p == 7) write_capacity(CAP_W'($urandom_range(1, 40)));
         else write_capacity(CAP_W'(PHASE_CAPS[p]));
         random_phase(PHASE_ITEMS);
      end

      // Last part, without idling: one long write request that fills the ring,
      // has room freed twice by reads, and finally drops its last two bytes.
      idle_on = 1'b0;
      drain_ring();
      write_capacity(CAP_W'(16));
      for (int unsigned round = 0; round < 2; round++) begin
         for (int unsigned k = 0; k < 12; k++) begin
            write_byte(BYTE_W'($urandom), round == 0 && k == 0, 1'b0);
         end
         read_request(LEN_W'(8));
      end
      for (int unsigned k = 0; k < 10; k++) write_byte(BYTE_W'($urandom), 1'b0, k == 9);
      stats_query();
      drain_ring();
      stats_query();

      settle();
      if (shadow.failures == 0) begin
         $display("byte_ring_fifo_with_stats_test passed");
      end else begin
         $display("byte_ring_fifo_with_stats_test failed");
      end
      $finish;
   end

endmodule
